// File: rtl/core/sgno_pkg.sv
package sgno_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	// Multiplier of the multiply-xorshift hash.
	localparam logic [31:0] HASH_MUL = 32'h5bd1e995;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_TOTAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 3'd4;

	// Result field widths.
	localparam int NOISE_SUM_W  = 21;
	localparam int NOISE_UNIT_W = 16;

	typedef struct packed {
		logic [31:0] noise_seed;
		logic [7:0]  base_frequency;
		logic [3:0]  octave_total;
		logic [15:0] persistence_q16;
		logic [9:0]  lacunarity_q8;
	} cfg_t;

	// Gradient components, selected by the low three bits of a corner hash.
	localparam logic signed [1:0] GRAD_X [8] = '{2'sb01, 2'sb11, 2'sb01, 2'sb11,
		2'sb01, 2'sb11, 2'sb00, 2'sb00};
	localparam logic signed [1:0] GRAD_Y [8] = '{2'sb01, 2'sb01, 2'sb11, 2'sb11,
		2'sb00, 2'sb00, 2'sb01, 2'sb11};

endpackage

// File: rtl/core/sgno_in_if.sv
interface sgno_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;

	modport source(output valid, output pos_x, output pos_y, input ready);
	modport sink(input valid, input pos_x, input pos_y, output ready);
endinterface

// File: rtl/core/sgno_out_if.sv
interface sgno_out_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] noise_sum;
	logic [15:0]        noise_unit;

	modport source(output valid, output noise_sum, output noise_unit, input ready);
	modport sink(input valid, input noise_sum, input noise_unit, output ready);
endinterface

// File: rtl/core/sgno_octave.sv
module sgno_octave #(
	parameter int OCT_IDX     = 0,
	parameter int MAX_OCTAVES = sgno_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = sgno_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  sgno_pkg::cfg_t      cfg,
	input  logic                cur_valid,
	input  logic [31:0]         cur_px,
	input  logic [31:0]         cur_py,
	input  logic [31:0]         cur_seed,
	input  logic [16+2*(MAX_OCTAVES-1)-1:0] cur_freq,
	input  logic [FRAC_BITS:0]  cur_amp,
	input  logic signed [FRAC_BITS+4+$clog2(MAX_OCTAVES)-1:0] cur_sum,
	output logic                nxt_valid,
	output logic [31:0]         nxt_px,
	output logic [31:0]         nxt_py,
	output logic [31:0]         nxt_seed,
	output logic [16+2*(MAX_OCTAVES-1)-1:0] nxt_freq,
	output logic [FRAC_BITS:0]  nxt_amp,
	output logic signed [FRAC_BITS+4+$clog2(MAX_OCTAVES)-1:0] nxt_sum
);

	localparam int L      = 13;
	localparam int F      = FRAC_BITS;
	localparam int FREQ_W = 16 + 2 * (MAX_OCTAVES - 1);
	localparam int AMP_W  = F + 1;
	localparam int SUM_W  = F + 4 + $clog2(MAX_OCTAVES);
	localparam int V_W    = F + 4;
	localparam int D_W    = F + 5;
	localparam int U_W    = F + 2;
	localparam int Q_W    = F + 5;
	localparam int FL_W   = FREQ_W + 10;
	localparam int AL_W   = AMP_W + 16;

	localparam logic signed [Q_W-1:0] C15   = Q_W'(15 << F);
	localparam logic signed [Q_W-1:0] C10   = Q_W'(10 << F);
	localparam logic signed [V_W-1:0] ONE_V = V_W'(1 << F);

	function automatic logic [31:0] mulm(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(sgno_pkg::HASH_MUL);
		return p[31:0];
	endfunction

	function automatic logic [31:0] xsm(input logic [31:0] x, input int sh);
		return mulm(x ^ (x >> sh));
	endfunction

	function automatic logic signed [V_W-1:0] gdot(input logic [2:0] g,
		input logic signed [V_W-1:0] dx, input logic signed [V_W-1:0] dy);
		logic signed [V_W-1:0] tx;
		logic signed [V_W-1:0] ty;
		tx = '0;
		ty = '0;
		if (sgno_pkg::GRAD_X[g] == 2'sb01) tx = dx;
		else if (sgno_pkg::GRAD_X[g] == 2'sb11) tx = -dx;
		if (sgno_pkg::GRAD_Y[g] == 2'sb01) ty = dy;
		else if (sgno_pkg::GRAD_Y[g] == 2'sb11) ty = -dy;
		return tx + ty;
	endfunction

	// Valid bits and carried values; array index is the stage number.
	logic [L:1]              vld_s;
	logic [31:0]             px_s   [1:L];
	logic [31:0]             py_s   [1:L];
	logic [FREQ_W-1:0]       nf_s   [1:L];
	logic [AMP_W-1:0]        na_s   [1:L];
	logic [AMP_W-1:0]        amp_s  [1:11];
	logic signed [SUM_W-1:0] sum_s  [1:12];
	logic [31:0]             seed_s [4:L];
	logic [F-1:0]            fx_s   [2:6];
	logic [F-1:0]            fy_s   [2:6];
	logic signed [U_W-1:0]   ux_s   [5:7];
	logic signed [U_W-1:0]   uy_s   [5:9];

	logic [55:0] plo_x_s1, plo_y_s1;
	logic [31:0] phi_x_s1, phi_y_s1, rk_s1;
	logic [31:0] cx_s2, cy_s2, rk_s2;
	logic [31:0] ax0_s3, ax1_s3, ay0_s3, ay1_s3, rk_s3;
	logic [F-1:0] t2x_s3, t2y_s3;
	logic signed [Q_W-1:0] qmx_s3, qmy_s3;
	logic [31:0] mx0_s4, mx1_s4, my0_s4, my1_s4, sm_s4;
	logic [F-1:0] t3x_s4, t3y_s4;
	logic signed [Q_W-1:0] inx_s4, iny_s4;
	logic [31:0] hx0_s5, hx1_s5, my0_s5, my1_s5;
	logic [17:0] f00_s6, f10_s6, f01_s6, f11_s6;
	logic signed [V_W-1:0] v1_s7, v2_s7, v3_s7, v4_s7;
	logic signed [V_W-1:0] p1_s8, p2_s8, v1_s8, v3_s8;
	logic signed [V_W-1:0] m1_s9, m2_s9;
	logic signed [V_W-1:0] p3_s10, m1_s10;
	logic signed [V_W-1:0] n_s11;
	logic signed [V_W-1:0] c_s12;
	logic signed [SUM_W-1:0] sum_s13;

	// Combinational terms between the registers.
	logic [47:0] fz;
	logic [FL_W-1:0] fl;
	logic [AL_W-1:0] al;
	logic [55:0] sx, sy;
	logic [2*F-1:0] sqx, sqy, cbx, cby;
	logic signed [Q_W-1:0] linx, liny;
	logic signed [F+Q_W:0] qpx, qpy, fpx, fpy;
	logic [31:0] sd;
	logic signed [V_W-1:0] dx0, dx1, dy0, dy1;
	logic [2:0] g00, g10, g01, g11;
	logic signed [D_W-1:0] d1, d2, d3;
	logic signed [U_W+D_W-1:0] pr1, pr2, pr3;
	logic signed [V_W+AMP_W:0] prc;
	logic act;

	assign fz   = 48'(cur_freq);
	assign fl   = FL_W'(cur_freq) * FL_W'(cfg.lacunarity_q8);
	assign al   = AL_W'(cur_amp) * AL_W'(cfg.persistence_q16);
	assign sx   = plo_x_s1 + {phi_x_s1, 24'b0};
	assign sy   = plo_y_s1 + {phi_y_s1, 24'b0};
	assign sqx  = (2*F)'(fx_s[2]) * (2*F)'(fx_s[2]);
	assign sqy  = (2*F)'(fy_s[2]) * (2*F)'(fy_s[2]);
	assign linx = $signed(Q_W'(fx_s[2]) * Q_W'(6)) - C15;
	assign liny = $signed(Q_W'(fy_s[2]) * Q_W'(6)) - C15;
	assign qpx  = $signed({1'b0, fx_s[2]}) * linx;
	assign qpy  = $signed({1'b0, fy_s[2]}) * liny;
	assign cbx  = (2*F)'(t2x_s3) * (2*F)'(fx_s[3]);
	assign cby  = (2*F)'(t2y_s3) * (2*F)'(fy_s[3]);
	assign sd   = rk_s3 ^ (rk_s3 >> 15);
	assign fpx  = $signed({1'b0, t3x_s4}) * inx_s4;
	assign fpy  = $signed({1'b0, t3y_s4}) * iny_s4;
	assign dx0  = $signed(V_W'(fx_s[6]));
	assign dy0  = $signed(V_W'(fy_s[6]));
	assign dx1  = dx0 - ONE_V;
	assign dy1  = dy0 - ONE_V;
	assign g00  = f00_s6[2:0] ^ f00_s6[17:15];
	assign g10  = f10_s6[2:0] ^ f10_s6[17:15];
	assign g01  = f01_s6[2:0] ^ f01_s6[17:15];
	assign g11  = f11_s6[2:0] ^ f11_s6[17:15];
	assign d1   = D_W'(v2_s7) - D_W'(v1_s7);
	assign d2   = D_W'(v4_s7) - D_W'(v3_s7);
	assign d3   = D_W'(m2_s9) - D_W'(m1_s9);
	assign pr1  = ux_s[7] * d1;
	assign pr2  = ux_s[7] * d2;
	assign pr3  = uy_s[9] * d3;
	assign prc  = n_s11 * $signed({1'b0, amp_s[11]});
	assign act  = cfg.octave_total > 4'(OCT_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-1:1], cur_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Carried values.
			px_s[1]   <= cur_px;
			py_s[1]   <= cur_py;
			nf_s[1]   <= fl[FREQ_W+7:8];
			na_s[1]   <= al[AMP_W+15:16];
			amp_s[1]  <= cur_amp;
			sum_s[1]  <= cur_sum;
			for (int k = 2; k <= L; k++) begin
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
				nf_s[k] <= nf_s[k-1];
				na_s[k] <= na_s[k-1];
			end
			for (int k = 2; k <= 11; k++) amp_s[k] <= amp_s[k-1];
			for (int k = 2; k <= 12; k++) sum_s[k] <= sum_s[k-1];
			for (int k = 5; k <= L; k++) seed_s[k] <= seed_s[k-1];
			for (int k = 3; k <= 6; k++) begin
				fx_s[k] <= fx_s[k-1];
				fy_s[k] <= fy_s[k-1];
			end
			for (int k = 6; k <= 7; k++) ux_s[k] <= ux_s[k-1];
			for (int k = 6; k <= 9; k++) uy_s[k] <= uy_s[k-1];

			// Stage 1: scale the position, start the seed rehash.
			plo_x_s1 <= 56'(cur_px) * 56'(fz[23:0]);
			plo_y_s1 <= 56'(cur_py) * 56'(fz[23:0]);
			phi_x_s1 <= 32'(56'(cur_px) * 56'(fz[47:24]));
			phi_y_s1 <= 32'(56'(cur_py) * 56'(fz[47:24]));
			rk_s1    <= mulm(cur_seed);

			// Stage 2: cell index and fraction.
			cx_s2    <= sx[55:24];
			cy_s2    <= sy[55:24];
			fx_s[2]  <= sx[23:24-F];
			fy_s[2]  <= sy[23:24-F];
			rk_s2    <= xsm(rk_s1, 24);

			// Stage 3: first key multiply, fade squares.
			ax0_s3   <= mulm(cx_s2);
			ax1_s3   <= mulm(cx_s2 + 32'd1);
			ay0_s3   <= mulm(cy_s2);
			ay1_s3   <= mulm(cy_s2 + 32'd1);
			rk_s3    <= xsm(rk_s2, 13);
			t2x_s3   <= sqx[2*F-1:F];
			t2y_s3   <= sqy[2*F-1:F];
			qmx_s3   <= Q_W'(qpx >>> F);
			qmy_s3   <= Q_W'(qpy >>> F);

			// Stage 4: finish the key mix, octave seed ready.
			mx0_s4    <= xsm(ax0_s3, 24);
			mx1_s4    <= xsm(ax1_s3, 24);
			my0_s4    <= xsm(ay0_s3, 24);
			my1_s4    <= xsm(ay1_s3, 24);
			seed_s[4] <= sd;
			sm_s4     <= mulm(sd);
			t3x_s4    <= cbx[2*F-1:F];
			t3y_s4    <= cby[2*F-1:F];
			inx_s4    <= qmx_s3 + C10;
			iny_s4    <= qmy_s3 + C10;

			// Stage 5: fold in the x key, fade values.
			hx0_s5   <= mulm(sm_s4 ^ mx0_s4);
			hx1_s5   <= mulm(sm_s4 ^ mx1_s4);
			my0_s5   <= my0_s4;
			my1_s5   <= my1_s4;
			ux_s[5]  <= U_W'(fpx >>> F);
			uy_s[5]  <= U_W'(fpy >>> F);

			// Stage 6: fold in the y key and finish each corner hash.
			f00_s6   <= 18'(xsm(hx0_s5 ^ my0_s5, 13));
			f10_s6   <= 18'(xsm(hx1_s5 ^ my0_s5, 13));
			f01_s6   <= 18'(xsm(hx0_s5 ^ my1_s5, 13));
			f11_s6   <= 18'(xsm(hx1_s5 ^ my1_s5, 13));

			// Stage 7: gradient dot products.
			v1_s7    <= gdot(g00, dx0, dy0);
			v2_s7    <= gdot(g10, dx1, dy0);
			v3_s7    <= gdot(g01, dx0, dy1);
			v4_s7    <= gdot(g11, dx1, dy1);

			// Stages 8 to 11: bilinear blend.
			p1_s8    <= V_W'(pr1 >>> F);
			p2_s8    <= V_W'(pr2 >>> F);
			v1_s8    <= v1_s7;
			v3_s8    <= v3_s7;
			m1_s9    <= v1_s8 + p1_s8;
			m2_s9    <= v3_s8 + p2_s8;
			p3_s10   <= V_W'(pr3 >>> F);
			m1_s10   <= m1_s9;
			n_s11    <= m1_s10 + p3_s10;

			// Stages 12 and 13: weight by amplitude and accumulate.
			c_s12    <= V_W'(prc >>> F);
			sum_s13  <= act ? sum_s[12] + SUM_W'(c_s12) : sum_s[12];
		end
	end

	assign nxt_valid = vld_s[L];
	assign nxt_px    = px_s[L];
	assign nxt_py    = py_s[L];
	assign nxt_seed  = seed_s[L];
	assign nxt_freq  = nf_s[L];
	assign nxt_amp   = na_s[L];
	assign nxt_sum   = sum_s13;

endmodule

// File: rtl/core/sgno_output.sv
module sgno_output #(
	parameter int MAX_OCTAVES = sgno_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = sgno_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sum_valid,
	input  logic signed [FRAC_BITS+4+$clog2(MAX_OCTAVES)-1:0] sum_val,
	output logic       pipe_en,
	sgno_out_if.source out_ch
);

	localparam int SUM_W   = FRAC_BITS + 4 + $clog2(MAX_OCTAVES);
	localparam int SH_R    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_L    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int S16_RAW = SUM_W + SH_L + 1;
	localparam int S16_W   = (S16_RAW > 24) ? S16_RAW : 24;
	localparam int NS_W    = sgno_pkg::NOISE_SUM_W;
	localparam int NU_W    = sgno_pkg::NOISE_UNIT_W;

	localparam logic signed [S16_W-1:0] SAT_HI  = S16_W'(1048575);
	localparam logic signed [S16_W-1:0] SAT_LO  = S16_W'(-1048576);
	localparam logic signed [S16_W:0]   U_HALF  = (S16_W+1)'(65536);
	localparam logic signed [S16_W:0]   U_MAX   = (S16_W+1)'(65535);

	logic signed [S16_W-1:0] ext, s16;
	logic signed [S16_W:0]   up, half;
	logic signed [NS_W-1:0]  sat_v;
	logic [NU_W-1:0]         unit_v;

	logic                    vld_s1;
	logic signed [NS_W-1:0]  nsum_s1;
	logic [NU_W-1:0]         unit_s1;
	logic                    out_vld_q, skd_vld_q;
	logic signed [NS_W-1:0]  out_sum_q, skd_sum_q;
	logic [NU_W-1:0]         out_unit_q, skd_unit_q;

	always_comb begin
		ext  = S16_W'(sum_val);
		s16  = (ext >>> SH_R) <<< SH_L;
		up   = (S16_W+1)'(s16) + U_HALF;
		half = up >>> 1;
		if (s16 > SAT_HI) sat_v = NS_W'(SAT_HI);
		else if (s16 < SAT_LO) sat_v = NS_W'(SAT_LO);
		else sat_v = NS_W'(s16);
		if (half < 0) unit_v = '0;
		else if (half > U_MAX) unit_v = '1;
		else unit_v = NU_W'(half);
	end

	// The skid register takes the item that leaves the pipeline while the
	// output register is stalled; the pipeline stops only while it is full.
	assign pipe_en = !skd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else begin
			if (pipe_en) vld_s1 <= sum_valid;
			if (out_ch.ready || !out_vld_q) begin
				out_vld_q <= skd_vld_q || vld_s1;
				skd_vld_q <= 1'b0;
			end else if (pipe_en && vld_s1) begin
				skd_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			nsum_s1 <= sat_v;
			unit_s1 <= unit_v;
		end
		if (out_ch.ready || !out_vld_q) begin
			out_sum_q  <= skd_vld_q ? skd_sum_q : nsum_s1;
			out_unit_q <= skd_vld_q ? skd_unit_q : unit_s1;
		end else if (pipe_en) begin
			skd_sum_q  <= nsum_s1;
			skd_unit_q <= unit_s1;
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.noise_sum  = out_sum_q;
	assign out_ch.noise_unit = out_unit_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> out_vld_q)
		else $error("skid register holds an item while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skd_vld_q) |-> $past(out_vld_q && !out_ch.ready))
		else $error("skid register filled without an output stall");

	a_sat_hi_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.noise_sum == 21'sh0fffff) |-> out_ch.noise_unit == 16'hffff)
		else $error("saturated high sum without full unit value");

	a_sat_lo_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.noise_sum == -21'sd1048576) |-> out_ch.noise_unit == 16'h0000)
		else $error("saturated low sum without zero unit value");

endmodule

// File: rtl/core/seeded_gradient_noise_octaves.sv
// Path: an accepted item passes through every octave section, then the output stage register and the output register.
// Throughput: one item per cycle while the receiver takes results; each octave is its own 13-stage pipeline section.
// An output register plus a skid register let an item enter while a result waits.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register reset values.
// No clearing pass is needed: the block is ready in the first cycle after reset.
module seeded_gradient_noise_octaves #(
	parameter int MAX_OCTAVES = sgno_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = sgno_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [sgno_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sgno_pkg::CFG_DATA_W-1:0]     wr_data,
	sgno_in_if.sink                             in_ch,
	sgno_out_if.source                          out_ch
);

	localparam int F      = FRAC_BITS;
	localparam int FREQ_W = 16 + 2 * (MAX_OCTAVES - 1);
	localparam int AMP_W  = F + 1;
	localparam int SUM_W  = F + 4 + $clog2(MAX_OCTAVES);

	// Configuration registers. The user must change them only while no item is in flight (the
	// block itself does not enforce this), so every pipeline stage may read them directly.
	sgno_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_seed      <= 32'd0;
			cfg_q.base_frequency  <= 8'd1;
			cfg_q.octave_total    <= 4'd1;
			cfg_q.persistence_q16 <= 16'd32768;
			cfg_q.lacunarity_q8   <= 10'd512;
		end else if (wr_en) begin
			unique case (wr_index)
				sgno_pkg::REG_NOISE_SEED:   cfg_q.noise_seed      <= wr_data[31:0];
				sgno_pkg::REG_BASE_FREQ:    cfg_q.base_frequency  <= wr_data[7:0];
				sgno_pkg::REG_OCTAVE_TOTAL: cfg_q.octave_total    <= wr_data[3:0];
				sgno_pkg::REG_PERSISTENCE:  cfg_q.persistence_q16 <= wr_data[15:0];
				sgno_pkg::REG_LACUNARITY:   cfg_q.lacunarity_q8   <= wr_data[9:0];
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	// Octave chain. Each section hands the next one the position, the seed it
	// used (the next section rehashes it), the next frequency and amplitude,
	// and the running sum. Sections past the configured octave count pass the
	// sum through unchanged, so the latency does not depend on configuration.
	logic                    pipe_en;
	logic                    vld_c  [0:MAX_OCTAVES];
	logic [31:0]             px_c   [0:MAX_OCTAVES];
	logic [31:0]             py_c   [0:MAX_OCTAVES];
	logic [31:0]             seed_c [0:MAX_OCTAVES];
	logic [FREQ_W-1:0]       freq_c [0:MAX_OCTAVES];
	logic [AMP_W-1:0]        amp_c  [0:MAX_OCTAVES];
	logic signed [SUM_W-1:0] sum_c  [0:MAX_OCTAVES];

	assign in_ch.ready = pipe_en;

	// First octave: frequency is base_frequency in Q.8, amplitude is one.
	assign vld_c[0]  = in_ch.valid;
	assign px_c[0]   = in_ch.pos_x;
	assign py_c[0]   = in_ch.pos_y;
	assign seed_c[0] = cfg_q.noise_seed;
	assign freq_c[0] = FREQ_W'({cfg_q.base_frequency, 8'b0});
	assign amp_c[0]  = AMP_W'(1 << F);
	assign sum_c[0]  = '0;

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		sgno_octave #(
			.OCT_IDX(k),
			.MAX_OCTAVES(MAX_OCTAVES),
			.FRAC_BITS(FRAC_BITS)
		) u_oct (
			.clk(clk),
			.arst_n(arst_n),
			.en(pipe_en),
			.cfg(cfg_q),
			.cur_valid(vld_c[k]),
			.cur_px(px_c[k]),
			.cur_py(py_c[k]),
			.cur_seed(seed_c[k]),
			.cur_freq(freq_c[k]),
			.cur_amp(amp_c[k]),
			.cur_sum(sum_c[k]),
			.nxt_valid(vld_c[k+1]),
			.nxt_px(px_c[k+1]),
			.nxt_py(py_c[k+1]),
			.nxt_seed(seed_c[k+1]),
			.nxt_freq(freq_c[k+1]),
			.nxt_amp(amp_c[k+1]),
			.nxt_sum(sum_c[k+1])
		);
	end

	// Scaling to Q4.16 with saturation, the unit value, and the output buffer.
	sgno_output #(
		.MAX_OCTAVES(MAX_OCTAVES),
		.FRAC_BITS(FRAC_BITS)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.sum_valid(vld_c[MAX_OCTAVES]),
		.sum_val(sum_c[MAX_OCTAVES]),
		.pipe_en(pipe_en),
		.out_ch(out_ch)
	);

endmodule

// File: tb/sv/sgno_scoreboard.sv
`timescale 1ns / 1ps

module sgno_scoreboard (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [sgno_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sgno_pkg::CFG_DATA_W-1:0] wr_data,
	sgno_in_if                              in_ch,
	sgno_out_if                             out_ch,
	output int                              fails,
	output int                              pending
);

	localparam longint ONE = 64'sd65536;

	typedef struct packed {
		logic signed [20:0] noise_sum;
		logic [15:0]        noise_unit;
	} noise_res_t;

	sgno_pkg::cfg_t regs;
	noise_res_t     noise_fifo[$];

	function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
		return a * b;
	endfunction

	function automatic logic [31:0] mix_key(logic [31:0] k);
		k = mul32(k, sgno_pkg::HASH_MUL);
		k = k ^ (k >> 24);
		return mul32(k, sgno_pkg::HASH_MUL);
	endfunction

	function automatic logic [31:0] avalanche(logic [31:0] h);
		h = h ^ (h >> 13);
		h = mul32(h, sgno_pkg::HASH_MUL);
		return h ^ (h >> 15);
	endfunction

	function automatic logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy,
		logic [31:0] seed);
		logic [31:0] h;
		h = mul32(seed, sgno_pkg::HASH_MUL) ^ mix_key(cx);
		h = mul32(h, sgno_pkg::HASH_MUL) ^ mix_key(cy);
		return avalanche(h);
	endfunction

	// Fixed-point product, rounded toward minus infinity.
	function automatic longint fxmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint fade(longint t);
		longint t3;
		t3 = fxmul(fxmul(t, t), t);
		return fxmul(t3, fxmul(t, 6 * t - 15 * ONE) + 10 * ONE);
	endfunction

	function automatic longint grad_dot(logic [31:0] h, longint dx, longint dy);
		longint gx, gy;
		gx = longint'(sgno_pkg::GRAD_X[h[2:0]]);
		gy = longint'(sgno_pkg::GRAD_Y[h[2:0]]);
		return gx * dx + gy * dy;
	endfunction

	function automatic longint cell_noise(logic [31:0] cx, logic [31:0] cy, longint fx,
		longint fy, logic [31:0] seed);
		longint v1, v2, v3, v4, ux, uy, m1, m2;
		v1 = grad_dot(cell_hash(cx, cy, seed), fx, fy);
		v2 = grad_dot(cell_hash(cx + 32'd1, cy, seed), fx - ONE, fy);
		v3 = grad_dot(cell_hash(cx, cy + 32'd1, seed), fx, fy - ONE);
		v4 = grad_dot(cell_hash(cx + 32'd1, cy + 32'd1, seed), fx - ONE, fy - ONE);
		ux = fade(fx);
		uy = fade(fy);
		m1 = v1 + fxmul(ux, v2 - v1);
		m2 = v3 + fxmul(ux, v4 - v3);
		return m1 + fxmul(uy, m2 - m1);
	endfunction

	function automatic noise_res_t fractal_noise(logic [31:0] px, logic [31:0] py);
		int                   count;
		logic [63:0]          freq, sx, sy;
		longint               amp, sum, unit;
		logic [31:0]          seed;
		noise_res_t           r;
		count = (regs.octave_total > sgno_pkg::MAX_OCTAVES_DEF) ?
			sgno_pkg::MAX_OCTAVES_DEF : int'(regs.octave_total);
		freq = 64'(regs.base_frequency) << 8;
		amp = ONE;
		seed = regs.noise_seed;
		sum = 0;
		for (int i = 0; i < count; i++) begin
			sx = 64'(px) * freq;
			sy = 64'(py) * freq;
			seed = avalanche(mix_key(seed));
			sum += fxmul(cell_noise(sx[55:24], sy[55:24], longint'(sx[23:8]),
				longint'(sy[23:8]), seed), amp);
			amp = (amp * longint'(regs.persistence_q16)) >>> 16;
			freq = (freq * 64'(regs.lacunarity_q8)) >> 8;
		end
		unit = (sum + ONE) >>> 1;
		if (unit < 0) unit = 0;
		if (unit > 65535) unit = 65535;
		if (sum > 1048575) sum = 1048575;
		if (sum < -1048576) sum = -1048576;
		r.noise_sum = sum[20:0];
		r.noise_unit = unit[15:0];
		return r;
	endfunction

	assign pending = noise_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		noise_res_t want;
		int         errs;
		errs = 0;
		if (!arst_n) begin
			regs <= '{32'd0, 8'd1, 4'd1, 16'd32768, 10'd512};
			fails <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					sgno_pkg::REG_NOISE_SEED:   regs.noise_seed <= wr_data;
					sgno_pkg::REG_BASE_FREQ:    regs.base_frequency <= wr_data[7:0];
					sgno_pkg::REG_OCTAVE_TOTAL: regs.octave_total <= wr_data[3:0];
					sgno_pkg::REG_PERSISTENCE:  regs.persistence_q16 <= wr_data[15:0];
					sgno_pkg::REG_LACUNARITY:   regs.lacunarity_q8 <= wr_data[9:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				noise_fifo.push_back(fractal_noise(in_ch.pos_x, in_ch.pos_y));
			if (out_ch.valid && out_ch.ready) begin
				if (noise_fifo.size() == 0) begin
					$error("noise result with nothing expected: sum %0d unit %0d",
						out_ch.noise_sum, out_ch.noise_unit);
					errs++;
				end else begin
					want = noise_fifo.pop_front();
					if (want.noise_sum !== out_ch.noise_sum) begin
						$error("noise_sum expected %0d actual %0d", want.noise_sum,
							out_ch.noise_sum);
						errs++;
					end
					if (want.noise_unit !== out_ch.noise_unit) begin
						$error("noise_unit expected %0d actual %0d", want.noise_unit,
							out_ch.noise_unit);
						errs++;
					end
				end
			end
			if (errs != 0) fails <= fails + errs;
		end
	end
endmodule

// File: tb/sv/tb_seeded_gradient_noise_octaves.sv
`timescale 1ns / 1ps

module tb_seeded_gradient_noise_octaves;

	// The block's pipeline depth with default parameters, plus some margin.
	localparam int DRAIN_CYCLES = 13 * sgno_pkg::MAX_OCTAVES_DEF + 20;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            wr_en = 1'b0;
	logic [sgno_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [sgno_pkg::CFG_DATA_W-1:0] wr_data = '0;
	int                              fails;
	int                              pending;

	// Idle rates in percent for the two sides; changed as the run goes on.
	int send_idle_pct = 37;
	int recv_idle_pct = 78;
	int random_sent = 0;

	// The long receiver hold-off is requested once and then runs on its own.
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;

	sgno_in_if  in_ch();
	sgno_out_if out_ch();

	seeded_gradient_noise_octaves dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	sgno_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_ch(in_ch), .out_ch(out_ch), .fails(fails),
		.pending(pending)
	);

	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		out_ch.ready = 1'b0;
	end

	// The receiver stalls at random, except during the one long hold-off, which
	// leaves the sender pushing until the pipeline is full and the input stalls.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_ch.ready <= 1'b0;
			hold_count = hold_count + 1;
			if (hold_count >= 400) hold_done = 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sends one item. Ready is sampled at the falling edge, where it is settled,
	// and the item counts as accepted at the next rising edge.
	task automatic send_pos(logic [31:0] x, logic [31:0] y);
		bit took;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pos_x <= x;
		in_ch.pos_y <= y;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end
	endtask

	// Lets the block drain completely before the registers change.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers back to back, then one index past the end of
	// the list, which the block must ignore.
	task automatic load_regs(logic [31:0] seed, logic [7:0] freq, logic [3:0] octs,
		logic [15:0] pers, logic [9:0] lac);
		logic [31:0] vals[5];
		vals = '{seed, 32'(freq), 32'(octs), 32'(pers), 32'(lac)};
		for (int i = 0; i < 5; i++) begin
			wr_en <= 1'b1;
			wr_index <= sgno_pkg::CFG_IDX_W'(i);
			wr_data <= vals[i];
			@(posedge clk);
		end
		wr_index <= sgno_pkg::CFG_IDX_W'($urandom_range(5, 7));
		wr_data <= $urandom;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Random positions: mostly full range, some near the origin where low
	// frequencies keep the cell indexes small.
	task automatic send_random(int n);
		logic [31:0] x, y;
		for (int i = 0; i < n; i++) begin
			if (random_sent < 233) begin
				send_idle_pct = 37;
				recv_idle_pct = 78;
			end else if (random_sent < 466) begin
				send_idle_pct = 78;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			x = $urandom;
			y = $urandom;
			if ($urandom_range(3) == 0) begin
				x = x >> $urandom_range(31);
				y = y >> $urandom_range(31);
			end
			send_pos(x, y);
			random_sent++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: corners of the position range, exact lattice points,
		// and points halfway inside a cell.
		send_pos(32'h0, 32'h0);
		send_pos(32'hffff_ffff, 32'hffff_ffff);
		send_pos(32'h0, 32'hffff_ffff);
		send_pos(32'hffff_ffff, 32'h0);
		send_pos(32'h0001_0000, 32'h0002_0000);
		send_pos(32'h0000_8000, 32'h0000_8000);
		send_pos(32'h0003_4000, 32'h0000_c000);
		send_pos(32'haaaa_aaaa, 32'h5555_5555);
		drain();

		// Every register at its top: huge scaled positions wrap the cell index,
		// and each octave keeps nearly the full amplitude of the one before.
		load_regs(32'hffff_ffff, 8'd255, 4'd8, 16'hffff, 10'd1023);
		send_pos(32'hffff_ffff, 32'hffff_ffff);
		send_pos(32'h5555_5555, 32'haaaa_aaaa);
		send_pos(32'h0000_0001, 32'h8000_0000);
		send_random(40);
		drain();

		// Zero frequency samples only the cell origin.
		load_regs(32'h1234_5678, 8'd0, 4'd8, 16'd40000, 10'd700);
		send_pos(32'hdead_beef, 32'h0bad_f00d);
		send_random(10);
		drain();

		// Zero octaves gives a flat mid-level result.
		load_regs(32'h0, 8'd1, 4'd0, 16'd0, 10'd256);
		send_pos(32'h0004_2000, 32'h0001_f000);
		send_random(10);
		drain();

		// An octave count above the maximum is limited to it; a lacunarity below
		// one shrinks the frequency from octave to octave.
		load_regs($urandom, 8'd200, 4'd15, 16'd60000, 10'd100);
		send_pos(32'hffff_0000, 32'h0000_ffff);
		send_random(60);
		drain();

		// Low extremes of persistence and lacunarity.
		load_regs($urandom, 8'd1, 4'd1, 16'd0, 10'd0);
		send_random(30);
		drain();

		// Several random settings, with the long receiver hold-off in the
		// middle of the unthrottled stretch. During the hold-off more items are
		// offered than the pipeline can hold, so the input stalls.
		for (int p = 0; p < 8; p++) begin
			load_regs($urandom, 8'($urandom_range(1, 255)), 4'($urandom_range(1, 8)),
				16'($urandom), 10'($urandom_range(256, 1023)));
			if (p == 6) hold_req = 1'b1;
			send_random((p == 6) ? 150 : 60);
			drain();
		end

		if (fails == 0) begin
			$display("tb_seeded_gradient_noise_octaves OK");
		end else begin
			$display("tb_seeded_gradient_noise_octaves NOT OK");
		end
		$finish;
	end

	initial begin
		#(12 * 1_000_000);
		$display("tb_seeded_gradient_noise_octaves NOT OK");
		$finish;
	end
endmodule
